FILE: hw/rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg: shared types, constants and calendar functions
// Date arithmetic helpers for the business day counter.
// ----------------------------------------------------------------------------
package bdc_pkg;

	localparam int MAX_SPAN = 1024;
	localparam int STEP_W   = $clog2(MAX_SPAN + 1);

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int MASK_W   = 7;
	localparam int WDAY_W   = 3;
	localparam int SUM_W    = 15;

	localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;
	localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_BEFORE  = 2'd2;
	localparam status_t ST_SPAN    = 2'd3;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
	} req_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] business_days;
		status_t            status;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;
		logic    load_div;
		logic    load_sum;
		logic    load_wday;
		logic    step;
		logic    load_out;
		status_t out_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_date;
		logic end_before;
		logic at_end;
		logic span_full;
	} dp_sts_t;

	// floor(x / 25) by reciprocal, exact for all 14-bit x
	function automatic logic [9:0] div25(input logic [YEAR_W-1:0] x);
		logic [26:0] prod;
		prod = 27'(x) * 27'd5243;
		return prod[26:17];
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [9:0]  q;
		logic [14:0] back;
		logic        by25;
		q    = div25(y);
		back = {q, 4'b0} + {1'b0, q, 3'b0} + 15'(q);
		by25 = (back == 15'(y));
		return (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
	                                                    input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = is_leap(y) ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
	                                 input logic [YEAR_W-1:0] y);
		return (y != '0) && (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) &&
		       (d != '0) && (d <= days_in_month(y, m));
	endfunction

	// (31 * mm) / 12 with March as month one
	function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] t;
		unique case (m)
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

	function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] s);
		logic [28:0] prod;
		logic [11:0] q;
		logic [14:0] q7;
		logic [3:0]  r;
		prod = 29'(s) * 29'd9362;
		q    = prod[27:16];
		q7   = {q, 3'b0} - 15'(q);
		r    = 4'(s - q7);
		if (r >= 4'd7) begin
			r = r - 4'd7;
		end
		return r[WDAY_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/bdc_if.sv
// ----------------------------------------------------------------------------
// bdc_if: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdc_req_if;
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::DAY_W-1:0]     start_day;
	logic [bdc_pkg::MONTH_W-1:0]   start_month;
	logic [bdc_pkg::YEAR_W-1:0]    start_year;
	logic [bdc_pkg::DAY_W-1:0]     end_day;
	logic [bdc_pkg::MONTH_W-1:0]   end_month;
	logic [bdc_pkg::YEAR_W-1:0]    end_year;

	modport source (output valid, start_day, start_month, start_year,
	                end_day, end_month, end_year, input ready);
	modport sink   (input valid, start_day, start_month, start_year,
	                end_day, end_month, end_year, output ready);
endinterface

interface bdc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::COUNT_W-1:0]   business_days;
	bdc_pkg::status_t              status;

	modport source (output valid, business_days, status, input ready);
	modport sink   (input valid, business_days, status, output ready);
endinterface

interface bdc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::MASK_W-1:0]    weekend_mask;

	modport source (output valid, weekend_mask, input ready);
	modport sink   (input valid, weekend_mask, output ready);
endinterface

FILE: hw/rtl/business_day_counter.sv
// Flow: a request is taken in idle and checked; good dates then pass the divide,
// sum and modulo states and the day walk; an invalid date or an end date before the
// start goes straight to finish. Throughput: no new request until the result is
// loaded; the day walker advances one calendar day per cycle, up to MAX_SPAN days.
// Reset: asynchronous, clears the sequencer and result valid, weekend_mask to 96.
// ----------------------------------------------------------------------------
// business_day_counter: business day count between two dates
// Counts days in [start, end) whose weekday is not set in weekend_mask.
// ----------------------------------------------------------------------------
module business_day_counter (
	input  logic        clk,
	input  logic        arst_n,
	bdc_cfg_if.sink     cfg,
	bdc_req_if.sink     req,
	bdc_rsp_if.source   rsp
);

	bdc_pkg::req_item_t  req_item;
	bdc_pkg::rsp_item_t  rsp_item;
	bdc_pkg::dp_cmd_t    cmd;
	bdc_pkg::dp_sts_t    sts;
	logic                req_ready;
	logic                rsp_valid;

	assign cfg.ready = 1'b1;

	assign req_item.start_day   = req.start_day;
	assign req_item.start_month = req.start_month;
	assign req_item.start_year  = req.start_year;
	assign req_item.end_day     = req.end_day;
	assign req_item.end_month   = req.end_month;
	assign req_item.end_year    = req.end_year;
	assign req.ready            = req_ready;

	assign rsp.valid         = rsp_valid;
	assign rsp.business_days = rsp_item.business_days;
	assign rsp.status        = rsp_item.status;

	bdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_mask (cfg.weekend_mask),
		.req_item (req_item),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_item (rsp_item)
	);

endmodule

FILE: hw/rtl/bdc_ctrl.sv
// ----------------------------------------------------------------------------
// bdc_ctrl: sequencing state machine
// Steps one transaction through check, weekday setup, day walk and result.
// ----------------------------------------------------------------------------
module bdc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bdc_pkg::dp_sts_t   sts,
	output bdc_pkg::dp_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_SUM    = 3'd3;
	localparam logic [2:0] S_MOD    = 3'd4;
	localparam logic [2:0] S_WALK   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]        state_q, state_d;
	bdc_pkg::status_t  fin_q, fin_d;
	logic              rsp_valid_q;
	logic              out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d        = state_q;
		fin_d          = fin_q;
		cmd            = '0;
		cmd.out_status = fin_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (sts.bad_date) begin
					fin_d   = bdc_pkg::ST_INVALID;
					state_d = S_FINISH;
				end else if (sts.end_before) begin
					fin_d   = bdc_pkg::ST_BEFORE;
					state_d = S_FINISH;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.load_div = 1'b1;
				state_d      = S_SUM;
			end
			S_SUM: begin
				cmd.load_sum = 1'b1;
				state_d      = S_MOD;
			end
			S_MOD: begin
				cmd.load_wday = 1'b1;
				state_d       = S_WALK;
			end
			S_WALK: begin
				priority if (sts.at_end) begin
					fin_d   = bdc_pkg::ST_OK;
					state_d = S_FINISH;
				end else if (sts.span_full) begin
					fin_d   = bdc_pkg::ST_SPAN;
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fin_q       <= bdc_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/bdc_dpath.sv
// ----------------------------------------------------------------------------
// bdc_dpath: date datapath
// Input capture, date checks, weekday pipeline, day walker and result register.
// ----------------------------------------------------------------------------
module bdc_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdc_pkg::MASK_W-1:0]    cfg_mask,
	input  bdc_pkg::req_item_t            req_item,
	input  bdc_pkg::dp_cmd_t              cmd,
	output bdc_pkg::dp_sts_t              sts,
	output bdc_pkg::rsp_item_t            rsp_item
);

	logic [bdc_pkg::MASK_W-1:0]   mask_q;
	bdc_pkg::req_item_t           item_q;

	logic [bdc_pkg::DAY_W-1:0]    walk_day_q;
	logic [bdc_pkg::MONTH_W-1:0]  walk_month_q;
	logic [bdc_pkg::YEAR_W-1:0]   walk_year_q;
	logic [bdc_pkg::WDAY_W-1:0]   walk_wday_q;
	logic [bdc_pkg::COUNT_W-1:0]  tally_q;
	logic [bdc_pkg::STEP_W-1:0]   steps_q;

	logic [bdc_pkg::YEAR_W-1:0]   yy_s1;
	logic [9:0]                   q100_s1, q400_s1;
	logic [bdc_pkg::DAY_W-1:0]    term_s1;
	logic [bdc_pkg::SUM_W-1:0]    sum_s2;

	bdc_pkg::rsp_item_t           out_q;

	logic [bdc_pkg::YEAR_W-1:0]   yy;
	logic [22:0]                  start_key, end_key, walk_key;
	logic                         month_end;

	assign start_key = {item_q.start_year, item_q.start_month, item_q.start_day};
	assign end_key   = {item_q.end_year, item_q.end_month, item_q.end_day};
	assign walk_key  = {walk_year_q, walk_month_q, walk_day_q};

	assign sts.bad_date =
		!bdc_pkg::date_ok(item_q.start_day, item_q.start_month, item_q.start_year) ||
		!bdc_pkg::date_ok(item_q.end_day, item_q.end_month, item_q.end_year);
	assign sts.end_before = (end_key < start_key);
	assign sts.at_end     = (walk_key == end_key);
	assign sts.span_full  = (steps_q == bdc_pkg::STEP_W'(bdc_pkg::MAX_SPAN));

	assign yy = (item_q.start_month <= 4'd2) ? item_q.start_year - 14'd1 : item_q.start_year;
	assign month_end = (walk_day_q >= bdc_pkg::days_in_month(walk_year_q, walk_month_q));

	assign rsp_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= bdc_pkg::MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q       <= '0;
			walk_day_q   <= '0;
			walk_month_q <= '0;
			walk_year_q  <= '0;
			walk_wday_q  <= '0;
			tally_q      <= '0;
			steps_q      <= '0;
		end else if (cmd.load_in) begin
			item_q       <= req_item;
			walk_day_q   <= req_item.start_day;
			walk_month_q <= req_item.start_month;
			walk_year_q  <= req_item.start_year;
			walk_wday_q  <= '0;
			tally_q      <= '0;
			steps_q      <= '0;
		end else if (cmd.load_wday) begin
			walk_wday_q <= bdc_pkg::mod7(sum_s2);
		end else if (cmd.step) begin
			if (!mask_q[walk_wday_q]) begin
				tally_q <= tally_q + 11'd1;
			end
			steps_q     <= steps_q + 11'd1;
			walk_wday_q <= (walk_wday_q == 3'd6) ? 3'd0 : walk_wday_q + 3'd1;
			if (month_end) begin
				walk_day_q <= 5'd1;
				if (walk_month_q >= 4'd12) begin
					walk_month_q <= 4'd1;
					walk_year_q  <= walk_year_q + 14'd1;
				end else begin
					walk_month_q <= walk_month_q + 4'd1;
				end
			end else begin
				walk_day_q <= walk_day_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			yy_s1   <= yy;
			q100_s1 <= bdc_pkg::div25({2'b00, yy[13:2]});
			q400_s1 <= bdc_pkg::div25({4'b0000, yy[13:4]});
			term_s1 <= bdc_pkg::month_term(item_q.start_month);
		end
		if (cmd.load_sum) begin
			sum_s2 <= bdc_pkg::SUM_W'(item_q.start_day) + bdc_pkg::SUM_W'(yy_s1)
			        + bdc_pkg::SUM_W'(yy_s1[13:2]) - bdc_pkg::SUM_W'(q100_s1)
			        + bdc_pkg::SUM_W'(q400_s1) + bdc_pkg::SUM_W'(term_s1);
		end
		if (cmd.load_out) begin
			out_q.status        <= cmd.out_status;
			out_q.business_days <= (cmd.out_status == bdc_pkg::ST_OK) ? tally_q : '0;
		end
	end

endmodule

FILE: hw/rtl/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker: port-level checks
// Watches the request and response channels of the business day counter.
// ----------------------------------------------------------------------------
module bdc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bdc_pkg::COUNT_W-1:0]  business_days,
	input bdc_pkg::status_t             status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(business_days) && $stable(status))
		else $error("response changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != bdc_pkg::ST_OK) |-> business_days == '0)
		else $error("nonzero count with error status");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(business_days) <= bdc_pkg::MAX_SPAN)
		else $error("count above maximum span");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

endmodule

bind business_day_counter bdc_checker u_bdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.business_days (rsp.business_days),
	.status        (rsp.status)
);
